>>> hdl/bfsp_pkg.sv
// ----------------------------------------------------------------------------
// bfsp_pkg
// Shared widths, command codes and record types of the shortest-path core.
// ----------------------------------------------------------------------------
`default_nettype none

package bfsp_pkg;

  localparam int MaxNodes   = 64;
  localparam int MaxEdges   = 256;
  localparam int WeightBits = 16;
  localparam int DistBits   = 32;

  localparam int NodeW  = $clog2(MaxNodes);
  localparam int NCntW  = $clog2(MaxNodes + 1);
  localparam int EdgeAW = $clog2(MaxEdges);
  localparam int ECntW  = $clog2(MaxEdges + 1);

  localparam logic [1:0] CmdClear = 2'd0;
  localparam logic [1:0] CmdLoad  = 2'd1;
  localparam logic [1:0] CmdRun   = 2'd2;

  typedef struct packed {
    logic [NodeW-1:0]             tail;
    logic [NodeW-1:0]             head;
    logic signed [WeightBits-1:0] weight;
  } edge_rec_t;

  typedef struct packed {
    logic signed [DistBits-1:0] cost;
    logic [NodeW-1:0]           pred;
  } node_rec_t;

  typedef struct packed {
    logic             en;
    logic [NodeW-1:0] addr;
    node_rec_t        data;
  } node_wr_t;

endpackage

`default_nettype wire

>>> hdl/bellman_ford_shortest_paths_core.sv
// ----------------------------------------------------------------------------
// bellman_ford_shortest_paths_core
// Single-source shortest paths by repeated edge relaxation over a loaded list.
//
//  channel  dir   handshake                  payload
//  in       in    in_valid_i / in_ready_o    command, source_node, edge_*
//  out      out   out_valid_o / out_ready_i  node, distance, reachable, ...
//  cfg      in    cfg_valid_i / cfg_ready_o  cfg_data_i (node_count)
//
// Clear and load beats are handled while idle. A run relaxes all E loaded
// edges in each of n+1 passes (n nodes in use), one edge at a time through
// read, add, compare and write-back in the node store, then emits a result
// beat per node. Reset clears counts and reached marks at once; no clearing
// pass. Input is held off until the last result beat leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module bellman_ford_shortest_paths_core (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire  [bfsp_pkg::NCntW-1:0]               cfg_data_i,
  input  wire                                      in_valid_i,
  output logic                                     in_ready_o,
  input  wire  [1:0]                               command_i,
  input  wire  [bfsp_pkg::NodeW-1:0]               source_node_i,
  input  wire  [bfsp_pkg::NodeW-1:0]               edge_from_i,
  input  wire  [bfsp_pkg::NodeW-1:0]               edge_to_i,
  input  wire  signed [bfsp_pkg::WeightBits-1:0]   edge_weight_i,
  output logic                                     out_valid_o,
  input  wire                                      out_ready_i,
  output logic [bfsp_pkg::NodeW-1:0]               node_o,
  output logic signed [bfsp_pkg::DistBits-1:0]     distance_o,
  output logic                                     reachable_o,
  output logic [bfsp_pkg::NodeW-1:0]               predecessor_o,
  output logic                                     has_predecessor_o,
  output logic                                     negative_cycle_o,
  output logic                                     last_o
);

  localparam int NodeW  = bfsp_pkg::NodeW;
  localparam int NCntW  = bfsp_pkg::NCntW;
  localparam int EdgeAW = bfsp_pkg::EdgeAW;
  localparam int ECntW  = bfsp_pkg::ECntW;
  localparam int DistW  = bfsp_pkg::DistBits;
  localparam int WgtW   = bfsp_pkg::WeightBits;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StStart = 3'd1;
  localparam logic [2:0] StERead = 3'd2;
  localparam logic [2:0] StNRead = 3'd3;
  localparam logic [2:0] StSum   = 3'd4;
  localparam logic [2:0] StUpd   = 3'd5;
  localparam logic [2:0] StORead = 3'd6;
  localparam logic [2:0] StOut   = 3'd7;

  localparam logic [NCntW-1:0] NodesMax = NCntW'(bfsp_pkg::MaxNodes);
  localparam logic [ECntW-1:0] EdgesMax = ECntW'(bfsp_pkg::MaxEdges);
  localparam logic signed [DistW-1:0] DistPosSat = {1'b0, {(DistW-1){1'b1}}};
  localparam logic signed [DistW-1:0] DistNegSat = {1'b1, {(DistW-1){1'b0}}};

  logic [2:0]              state_q, state_d;
  logic [NCntW-1:0]        node_count_q;
  logic [NCntW-1:0]        n_q, n_d;
  logic [ECntW-1:0]        edges_q, edges_d;
  logic [ECntW-1:0]        e_q, e_d;
  logic [NCntW-1:0]        pass_q, pass_d;
  logic [NodeW-1:0]        idx_q, idx_d;
  logic [NodeW-1:0]        src_q;
  logic                    cycle_q, cycle_d;
  logic [bfsp_pkg::MaxNodes-1:0] reached_q, reached_d;
  logic [bfsp_pkg::MaxNodes-1:0] has_pred_q, has_pred_d;

  // per-edge datapath registers
  logic [NodeW-1:0]        u_q, v_q;
  logic signed [WgtW-1:0]  w_q;
  logic                    skip_q;
  logic signed [DistW-1:0] sum_q, dv_q;

  logic                    in_beat;
  logic                    edge_wr_en;
  bfsp_pkg::edge_rec_t     edge_wr_data, edge_rd_data;
  logic [EdgeAW-1:0]       edge_rd_addr;
  bfsp_pkg::node_wr_t      node_wr;
  logic [NodeW-1:0]        node_addr_a, node_addr_b;
  bfsp_pkg::node_rec_t     node_rd_a, node_rd_b;

  logic [DistW:0]          sum_wide;
  logic signed [DistW-1:0] sum_sat;
  logic                    better;
  logic                    last_node;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == StIdle);
  assign in_beat     = in_valid_i && in_ready_o;

  assign edge_wr_en          = in_beat && (command_i == bfsp_pkg::CmdLoad) && (edges_q < EdgesMax);
  assign edge_wr_data.tail   = edge_from_i;
  assign edge_wr_data.head   = edge_to_i;
  assign edge_wr_data.weight = edge_weight_i;
  assign edge_rd_addr        = e_q[EdgeAW-1:0];

  bfsp_edge_mem u_edge_mem (
    .clk_i     (clk_i),
    .wr_en_i   (edge_wr_en),
    .wr_addr_i (edges_q[EdgeAW-1:0]),
    .wr_data_i (edge_wr_data),
    .rd_addr_i (edge_rd_addr),
    .rd_data_o (edge_rd_data)
  );

  bfsp_node_mem u_node_mem (
    .clk_i       (clk_i),
    .wr_i        (node_wr),
    .rd_addr_a_i (node_addr_a),
    .rd_addr_b_i (node_addr_b),
    .rd_data_a_o (node_rd_a),
    .rd_data_b_o (node_rd_b)
  );

  // read ports: tail/head during relaxation, the result node while emitting
  always_comb begin
    node_addr_a = idx_q;
    node_addr_b = v_q;
    if (state_q == StNRead) begin
      node_addr_a = edge_rd_data.tail;
      node_addr_b = edge_rd_data.head;
    end
  end

  assign sum_wide = {node_rd_a.cost[DistW-1], node_rd_a.cost}
                  + {{(DistW-WgtW+1){w_q[WgtW-1]}}, w_q};
  always_comb begin
    if (sum_wide[DistW] != sum_wide[DistW-1]) begin
      sum_sat = sum_wide[DistW] ? DistNegSat : DistPosSat;
    end else begin
      sum_sat = sum_wide[DistW-1:0];
    end
  end

  assign better    = !reached_q[v_q] || (sum_q < dv_q);
  assign last_node = ({1'b0, idx_q} == n_q - NCntW'(1));

  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    edges_d    = edges_q;
    e_d        = e_q;
    pass_d     = pass_q;
    idx_d      = idx_q;
    cycle_d    = cycle_q;
    reached_d  = reached_q;
    has_pred_d = has_pred_q;
    node_wr    = '0;

    case (state_q)
      StIdle: begin
        if (in_beat) begin
          case (command_i)
            bfsp_pkg::CmdClear: edges_d = '0;
            bfsp_pkg::CmdLoad: begin
              if (edge_wr_en) begin
                edges_d = edges_q + ECntW'(1);
              end
            end
            bfsp_pkg::CmdRun: begin
              if (node_count_q == '0) begin
                n_d = NCntW'(1);
              end else if (node_count_q > NodesMax) begin
                n_d = NodesMax;
              end else begin
                n_d = node_count_q;
              end
              reached_d  = '0;
              has_pred_d = '0;
              cycle_d    = 1'b0;
              e_d        = '0;
              pass_d     = '0;
              idx_d      = '0;
              state_d    = StStart;
            end
            default: ;
          endcase
        end
      end
      StStart: begin
        if ({1'b0, src_q} < n_q) begin
          node_wr.en        = 1'b1;
          node_wr.addr      = src_q;
          node_wr.data.cost = '0;
          node_wr.data.pred = '0;
          reached_d[src_q]  = 1'b1;
        end
        state_d = (edges_q == '0) ? StORead : StERead;
      end
      StERead: state_d = StNRead;
      StNRead: state_d = StSum;
      StSum:   state_d = StUpd;
      StUpd: begin
        // strictly one edge in flight, so the next read sees this write
        if (!skip_q && better) begin
          if (pass_q == n_q) begin
            cycle_d = 1'b1;
          end else begin
            node_wr.en        = 1'b1;
            node_wr.addr      = v_q;
            node_wr.data.cost = sum_q;
            node_wr.data.pred = u_q;
            reached_d[v_q]    = 1'b1;
            has_pred_d[v_q]   = 1'b1;
          end
        end
        if (e_q + ECntW'(1) == edges_q) begin
          e_d = '0;
          if (pass_q == n_q) begin
            state_d = StORead;
          end else begin
            pass_d  = pass_q + NCntW'(1);
            state_d = StERead;
          end
        end else begin
          e_d     = e_q + ECntW'(1);
          state_d = StERead;
        end
      end
      StORead: state_d = StOut;
      StOut: begin
        if (out_ready_i) begin
          if (last_node) begin
            state_d = StIdle;
          end else begin
            idx_d   = idx_q + NodeW'(1);
            state_d = StORead;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      node_count_q <= NodesMax;
      n_q          <= NodesMax;
      edges_q      <= '0;
      e_q          <= '0;
      pass_q       <= '0;
      idx_q        <= '0;
      cycle_q      <= 1'b0;
      reached_q    <= '0;
      has_pred_q   <= '0;
    end else begin
      state_q    <= state_d;
      n_q        <= n_d;
      edges_q    <= edges_d;
      e_q        <= e_d;
      pass_q     <= pass_d;
      idx_q      <= idx_d;
      cycle_q    <= cycle_d;
      reached_q  <= reached_d;
      has_pred_q <= has_pred_d;
      if (cfg_valid_i && cfg_ready_o) begin
        node_count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat && (command_i == bfsp_pkg::CmdRun)) begin
      src_q <= source_node_i;
    end
    if (state_q == StNRead) begin
      u_q    <= edge_rd_data.tail;
      v_q    <= edge_rd_data.head;
      w_q    <= edge_rd_data.weight;
      skip_q <= ({1'b0, edge_rd_data.tail} >= n_q) || ({1'b0, edge_rd_data.head} >= n_q)
             || !reached_q[edge_rd_data.tail];
    end
    if (state_q == StSum) begin
      sum_q <= sum_sat;
      dv_q  <= node_rd_b.cost;
    end
  end

  assign out_valid_o       = (state_q == StOut);
  assign node_o            = idx_q;
  assign reachable_o       = reached_q[idx_q];
  assign distance_o        = reached_q[idx_q] ? node_rd_a.cost : '0;
  assign has_predecessor_o = has_pred_q[idx_q];
  assign predecessor_o     = has_pred_q[idx_q] ? node_rd_a.pred : '0;
  assign negative_cycle_o  = last_node && cycle_q;
  assign last_o            = last_node;

endmodule

`default_nettype wire

>>> hdl/bfsp_edge_mem.sv
// ----------------------------------------------------------------------------
// bfsp_edge_mem
// Edge list store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsp_edge_mem (
  input  wire                              clk_i,
  input  wire                              wr_en_i,
  input  wire  [bfsp_pkg::EdgeAW-1:0]      wr_addr_i,
  input  bfsp_pkg::edge_rec_t              wr_data_i,
  input  wire  [bfsp_pkg::EdgeAW-1:0]      rd_addr_i,
  output bfsp_pkg::edge_rec_t              rd_data_o
);

  bfsp_pkg::edge_rec_t mem_q [bfsp_pkg::MaxEdges];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

`default_nettype wire

>>> hdl/bfsp_node_mem.sv
// ----------------------------------------------------------------------------
// bfsp_node_mem
// Per-node distance and predecessor store: one write port, two read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsp_node_mem (
  input  wire                              clk_i,
  input  bfsp_pkg::node_wr_t               wr_i,
  input  wire  [bfsp_pkg::NodeW-1:0]       rd_addr_a_i,
  input  wire  [bfsp_pkg::NodeW-1:0]       rd_addr_b_i,
  output bfsp_pkg::node_rec_t              rd_data_a_o,
  output bfsp_pkg::node_rec_t              rd_data_b_o
);

  bfsp_pkg::node_rec_t mem_q [bfsp_pkg::MaxNodes];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_data_a_o <= mem_q[rd_addr_a_i];
    rd_data_b_o <= mem_q[rd_addr_b_i];
  end

endmodule

`default_nettype wire
